// ----- hdl/xml_entity_escape_codec_assert.svh -----
// Assertion macros for the entity codec. Empty when SYNTH is defined.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef XML_ENTITY_ESCAPE_CODEC_ASSERT_SVH
`define XML_ENTITY_ESCAPE_CODEC_ASSERT_SVH

`ifndef SYNTH
`define XEC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xec: same-cycle check failed");
`define XEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xec: next-cycle check failed");
`else
`define XEC_ASSERT_IMPLY(lbl, ante, cons)
`define XEC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/xec_pkg.sv -----
`default_nettype none

package xec_pkg;

	localparam int NumEnt    = 5;
	localparam int HeldDepth = 5;

	localparam logic [7:0] AmpChar  = "&";
	localparam logic [7:0] LtChar   = "<";
	localparam logic [7:0] GtChar   = ">";
	localparam logic [7:0] AposChar = "'";
	localparam logic [7:0] QuotChar = "\"";

	typedef enum logic [2:0] {
		ENT_LT,
		ENT_GT,
		ENT_AMP,
		ENT_APOS,
		ENT_QUOT
	} ent_idx_t;

	// microcode step addresses
	typedef enum logic [3:0] {
		U_FETCH,
		U_ESC_TEST,
		U_ESC_AMP,
		U_ESC_BODY,
		U_FINISH,
		U_ESC_BYTE,
		U_MATCH,
		U_FULL_TEST,
		U_ENT_CHAR,
		U_FLUSH_AMP,
		U_FLUSH_HELD,
		U_FRESH,
		U_FIN_TEST,
		U_FIN_AMP,
		U_FIN_HELD
	} upc_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_FETCH,
		OP_ESC_LOOKUP,
		OP_MATCH,
		OP_CLOSE,
		OP_FRESH,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		SRC_NONE,
		SRC_BYTE,
		SRC_AMP,
		SRC_BODY,
		SRC_HELD,
		SRC_ENT
	} src_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_DISPATCH,
		C_NO_ESC,
		C_BODY_MORE,
		C_HELD_MORE,
		C_CNT_ZERO,
		C_PREFIX,
		C_NOT_FULL,
		C_NO_FLUSH
	} cond_t;

	// rpt: hold this step while true; jmp: go to target when true, else next step
	typedef struct packed {
		op_t   op;
		src_t  src;
		cond_t rpt;
		cond_t jmp;
		upc_t  target;
	} ucw_t;

	function automatic ucw_t ucode(input upc_t u);
		ucw_t w;
		w = '{op: OP_NOP, src: SRC_NONE, rpt: C_NEVER, jmp: C_ALWAYS, target: U_FETCH};
		case (u)
			U_FETCH:      w = '{OP_FETCH,      SRC_NONE, C_NEVER,     C_DISPATCH, U_FETCH};
			U_ESC_TEST:   w = '{OP_ESC_LOOKUP, SRC_NONE, C_NEVER,     C_NO_ESC,   U_ESC_BYTE};
			U_ESC_AMP:    w = '{OP_NOP,        SRC_AMP,  C_NEVER,     C_NEVER,    U_FETCH};
			U_ESC_BODY:   w = '{OP_NOP,        SRC_BODY, C_BODY_MORE, C_ALWAYS,   U_FINISH};
			U_FINISH:     w = '{OP_FINISH,     SRC_NONE, C_NEVER,     C_ALWAYS,   U_FETCH};
			U_ESC_BYTE:   w = '{OP_NOP,        SRC_BYTE, C_NEVER,     C_ALWAYS,   U_FINISH};
			U_MATCH:      w = '{OP_MATCH,      SRC_NONE, C_NEVER,     C_PREFIX,   U_FIN_TEST};
			U_FULL_TEST:  w = '{OP_NOP,        SRC_NONE, C_NEVER,     C_NOT_FULL, U_FLUSH_AMP};
			U_ENT_CHAR:   w = '{OP_CLOSE,      SRC_ENT,  C_NEVER,     C_ALWAYS,   U_FIN_TEST};
			U_FLUSH_AMP:  w = '{OP_NOP,        SRC_AMP,  C_NEVER,     C_CNT_ZERO, U_FRESH};
			U_FLUSH_HELD: w = '{OP_NOP,        SRC_HELD, C_HELD_MORE, C_NEVER,    U_FETCH};
			U_FRESH:      w = '{OP_FRESH,      SRC_BYTE, C_NEVER,     C_NEVER,    U_FETCH};
			U_FIN_TEST:   w = '{OP_NOP,        SRC_NONE, C_NEVER,     C_NO_FLUSH, U_FINISH};
			U_FIN_AMP:    w = '{OP_NOP,        SRC_AMP,  C_NEVER,     C_CNT_ZERO, U_FINISH};
			U_FIN_HELD:   w = '{OP_NOP,        SRC_HELD, C_HELD_MORE, C_ALWAYS,   U_FINISH};
			default:      w = '{OP_NOP,        SRC_NONE, C_NEVER,     C_ALWAYS,   U_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic [7:0] ent_char(input ent_idx_t e);
		logic [7:0] c;
		case (e)
			ENT_LT:   c = LtChar;
			ENT_GT:   c = GtChar;
			ENT_AMP:  c = AmpChar;
			ENT_APOS: c = AposChar;
			ENT_QUOT: c = QuotChar;
			default:  c = AmpChar;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] ent_len(input ent_idx_t e);
		logic [2:0] n;
		case (e)
			ENT_LT:   n = 3'd3;
			ENT_GT:   n = 3'd3;
			ENT_AMP:  n = 3'd4;
			ENT_APOS: n = 3'd5;
			ENT_QUOT: n = 3'd5;
			default:  n = 3'd3;
		endcase
		return n;
	endfunction

	// body text after the ampersand; zero past the end
	function automatic logic [7:0] ent_body(input ent_idx_t e, input logic [2:0] p);
		logic [7:0] c;
		c = 8'h00;
		case (e)
			ENT_LT: begin
				case (p)
					3'd0:    c = "l";
					3'd1:    c = "t";
					3'd2:    c = ";";
					default: c = 8'h00;
				endcase
			end
			ENT_GT: begin
				case (p)
					3'd0:    c = "g";
					3'd1:    c = "t";
					3'd2:    c = ";";
					default: c = 8'h00;
				endcase
			end
			ENT_AMP: begin
				case (p)
					3'd0:    c = "a";
					3'd1:    c = "m";
					3'd2:    c = "p";
					3'd3:    c = ";";
					default: c = 8'h00;
				endcase
			end
			ENT_APOS: begin
				case (p)
					3'd0:    c = "a";
					3'd1:    c = "p";
					3'd2:    c = "o";
					3'd3:    c = "s";
					3'd4:    c = ";";
					default: c = 8'h00;
				endcase
			end
			ENT_QUOT: begin
				case (p)
					3'd0:    c = "q";
					3'd1:    c = "u";
					3'd2:    c = "o";
					3'd3:    c = "t";
					3'd4:    c = ";";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/xml_entity_escape_codec.sv -----
// Channel   Dir  Handshake              Payload
// cfg       in   cfg_valid/cfg_ready    direction (0 escape, 1 unescape)
// char      in   char_valid/char_ready  data_byte[7:0], is_final
// res       out  res_valid/res_ready    out_byte[7:0], run_end, string_end
//
// One request at a time; the sequencer issues one control word per cycle unless a step
// stalls, and each step produces at most one result byte. Escape emits the byte or
// its entity. Unescape passes a byte, opens or extends an entity, closes a complete
// one, or flushes the ampersand and held bytes when a byte breaks it or the string ends.
// A full result register stalls the step that hands it a byte.
// Reset clears the sequencer, direction and entity state; held bytes need no clearing.
`default_nettype none
`include "xml_entity_escape_codec_assert.svh"

module xml_entity_escape_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       direction,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] data_byte,
	input  logic       is_final,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_end
);
	import xec_pkg::*;

	// sequencer
	upc_t       upc_q;
	upc_t       upc_d;
	ucw_t       cw;

	// architectural state
	logic       dir_q;
	logic       open_q;
	logic [2:0] cnt_q;
	logic [7:0] held_q [HeldDepth];

	// datapath registers
	logic [7:0] b_q;
	logic       fin_q;
	ent_idx_t   ent_q;
	logic       full_q;
	logic [2:0] ptr_q;

	// one-deep pending byte: lets the last byte of a request carry run_end
	logic       pend_valid_q;
	logic [7:0] pend_q;

	// result register
	logic       res_valid_q;
	logic [7:0] res_byte_q;
	logic       run_end_q;
	logic       string_end_q;

	logic       cfg_acc;
	logic       char_acc;
	logic       esc_hit;
	ent_idx_t   esc_idx;
	logic       m_prefix;
	logic       m_full;
	ent_idx_t   m_idx;
	logic [7:0] emit_byte;
	logic       emit_en;
	logic       push;
	logic       res_free;
	logic       go;
	logic       rpt_hit;
	logic       jmp_hit;
	upc_t       jmp_target;

	assign cfg_ready  = (upc_q == U_FETCH);
	assign char_ready = (upc_q == U_FETCH) && !cfg_valid;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign char_acc   = char_valid && char_ready;

	assign res_valid  = res_valid_q;
	assign out_byte   = res_byte_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

	// escape-mode lookup of the current byte
	always_comb begin
		esc_hit = 1'b1;
		case (b_q)
			LtChar:   esc_idx = ENT_LT;
			GtChar:   esc_idx = ENT_GT;
			AmpChar:  esc_idx = ENT_AMP;
			AposChar: esc_idx = ENT_APOS;
			QuotChar: esc_idx = ENT_QUOT;
			default: begin
				esc_hit = 1'b0;
				esc_idx = ENT_LT;
			end
		endcase
	end

	// held bytes plus the new byte against every entity body
	always_comb begin
		logic       ok;
		logic [7:0] c;
		logic [2:0] len;
		m_prefix = 1'b0;
		m_full   = 1'b0;
		m_idx    = ENT_LT;
		for (int e = 0; e < NumEnt; e++) begin
			len = ent_len(ent_idx_t'(3'(e)));
			ok  = ((cnt_q + 3'd1) <= len);
			for (int i = 0; i < HeldDepth; i++) begin
				c = (3'(i) < cnt_q) ? held_q[i] : b_q;
				if (3'(i) <= cnt_q && c != ent_body(ent_idx_t'(3'(e)), 3'(i))) begin
					ok = 1'b0;
				end
			end
			if (ok && (cnt_q + 3'd1) == len) begin
				m_full = 1'b1;
				m_idx  = ent_idx_t'(3'(e));
			end else if (ok) begin
				m_prefix = 1'b1;
			end
		end
	end

	// control word decode, stall and next step
	always_comb begin
		cw = ucode(upc_q);

		case (cw.src)
			SRC_BYTE: emit_byte = b_q;
			SRC_AMP:  emit_byte = AmpChar;
			SRC_BODY: emit_byte = ent_body(ent_q, ptr_q);
			SRC_HELD: emit_byte = held_q[ptr_q];
			SRC_ENT:  emit_byte = ent_char(ent_q);
			default:  emit_byte = 8'h00;
		endcase

		// a fresh ampersand opens an entity instead of printing
		emit_en  = (cw.src != SRC_NONE) && !(cw.op == OP_FRESH && b_q == AmpChar);
		push     = pend_valid_q && (emit_en || cw.op == OP_FINISH);
		res_free = !res_valid_q || res_ready;
		go       = (cw.op == OP_FETCH) ? char_acc : (!push || res_free);

		case (cw.rpt)
			C_BODY_MORE: rpt_hit = (ptr_q != ent_len(ent_q) - 3'd1);
			C_HELD_MORE: rpt_hit = ((ptr_q + 3'd1) != cnt_q);
			default:     rpt_hit = 1'b0;
		endcase

		jmp_target = cw.target;
		case (cw.jmp)
			C_ALWAYS:    jmp_hit = 1'b1;
			C_DISPATCH: begin
				jmp_hit = 1'b1;
				if (!dir_q) begin
					jmp_target = U_ESC_TEST;
				end else if (open_q) begin
					jmp_target = U_MATCH;
				end else begin
					jmp_target = U_FRESH;
				end
			end
			C_NO_ESC:    jmp_hit = !esc_hit;
			C_CNT_ZERO:  jmp_hit = (cnt_q == 3'd0);
			C_PREFIX:    jmp_hit = m_prefix;
			C_NOT_FULL:  jmp_hit = !full_q;
			C_NO_FLUSH:  jmp_hit = !(fin_q && open_q);
			default:     jmp_hit = 1'b0;
		endcase

		if (!go || rpt_hit) begin
			upc_d = upc_q;
		end else if (jmp_hit) begin
			upc_d = jmp_target;
		end else begin
			upc_d = upc_t'(4'(upc_q + 4'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_FETCH;
		end else begin
			upc_q <= upc_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q        <= 1'b0;
			open_q       <= 1'b0;
			cnt_q        <= 3'd0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_acc) begin
				// new direction drops any half-read entity
				dir_q  <= direction;
				open_q <= 1'b0;
				cnt_q  <= 3'd0;
			end else if (go) begin
				case (cw.op)
					OP_MATCH: begin
						if (m_prefix) begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
					OP_CLOSE: begin
						open_q <= 1'b0;
						cnt_q  <= 3'd0;
					end
					OP_FRESH: begin
						open_q <= (b_q == AmpChar);
						cnt_q  <= 3'd0;
					end
					OP_FINISH: begin
						if (fin_q) begin
							open_q <= 1'b0;
							cnt_q  <= 3'd0;
						end
					end
					default: ;
				endcase
			end

			if (go && emit_en) begin
				pend_valid_q <= 1'b1;
			end else if (go && cw.op == OP_FINISH) begin
				pend_valid_q <= 1'b0;
			end

			if (go && push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (char_acc) begin
			b_q   <= data_byte;
			fin_q <= is_final;
		end
		if (go) begin
			if (cw.op == OP_ESC_LOOKUP) begin
				ent_q <= esc_idx;
			end
			if (cw.op == OP_MATCH) begin
				ent_q  <= m_idx;
				full_q <= m_full;
				if (m_prefix) begin
					held_q[cnt_q] <= b_q;
				end
			end
			if (cw.src == SRC_AMP) begin
				ptr_q <= 3'd0;
			end else if (cw.src == SRC_BODY || cw.src == SRC_HELD) begin
				ptr_q <= ptr_q + 3'd1;
			end
			if (emit_en) begin
				pend_q <= emit_byte;
			end
			if (push) begin
				res_byte_q   <= pend_q;
				run_end_q    <= (cw.op == OP_FINISH);
				string_end_q <= (cw.op == OP_FINISH) && fin_q;
			end
		end
	end

	// a new request only starts once the previous one has drained its pending byte
	`XEC_ASSERT_IMPLY(a_idle_no_pending, char_ready, !pend_valid_q)
	// with no ampersand open nothing may be held
	`XEC_ASSERT_IMPLY(a_closed_nothing_held, !open_q, cnt_q == 3'd0)
	// an accepted request always moves the sequencer off the fetch step
	`XEC_ASSERT_NEXT(a_accept_starts_program, char_valid && char_ready, upc_q != U_FETCH)

endmodule

`default_nettype wire
